[src/ate_pkg.sv]
// ----------------------------------------------------------------------------
// ate_pkg
// Types, codes and defaults shared by the array table engine.
// ----------------------------------------------------------------------------
package ate_pkg;

	localparam int DEPTH_DEF = 128;
	localparam logic [7:0] CAPACITY_RESET = 8'd128;

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_SORT   = 3'd3,
		CMD_SEARCH = 3'd4,
		CMD_READ   = 3'd5,
		CMD_CLEAR  = 3'd6,
		CMD_NOP    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_CHK,
		S_INS_WR,
		S_DEL_CHK,
		S_DEL_CMP,
		S_DEL_SH,
		S_DEL_WR,
		S_SRT_OUT,
		S_SRT_KEY,
		S_SRT_CHK,
		S_SRT_CMP,
		S_BS_CHK,
		S_BS_CMP,
		S_RD_DATA,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		RA_J,
		RA_JM1,
		RA_JP1,
		RA_MID,
		RA_POS,
		RA_I
	} raddr_sel_t;

	typedef enum logic {
		WA_J,
		WA_COUNT
	} waddr_sel_t;

	typedef enum logic [1:0] {
		WD_VALUE,
		WD_RDATA,
		WD_KEY
	} wdata_sel_t;

	typedef enum logic [2:0] {
		J_HOLD,
		J_COUNT,
		J_ZERO,
		J_I,
		J_DEC,
		J_INC,
		J_MID
	} j_op_t;

	typedef enum logic [1:0] {
		I_HOLD,
		I_ONE,
		I_INC
	} i_op_t;

	typedef enum logic [1:0] {
		BS_HOLD,
		BS_INIT,
		BS_LO,
		BS_HI
	} bs_op_t;

	typedef enum logic [1:0] {
		C_HOLD,
		C_INC,
		C_DEC,
		C_CLR
	} cnt_op_t;

	typedef struct packed {
		logic       latch;
		logic       mem_rd;
		raddr_sel_t raddr_sel;
		logic       mem_wr;
		waddr_sel_t waddr_sel;
		wdata_sel_t wdata_sel;
		j_op_t      j_op;
		i_op_t      i_op;
		logic       key_ld;
		bs_op_t     bs_op;
		cnt_op_t    cnt_op;
		logic       st_ld;
		status_t    st_val;
		logic       found_set;
		logic       rd_ld;
		logic       out_ld;
	} dp_ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic ins_bad;
		logic rd_bad;
		logic j_at_ins;
		logic j_zero;
		logic j_at_count;
		logic j_last;
		logic i_done;
		logic eq_value;
		logic gt_key;
		logic lt_value;
		logic lo_ge_hi;
	} dp_flags_t;

endpackage

[src/ate_ifs.sv]
// ----------------------------------------------------------------------------
// ate_in_if / ate_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface ate_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [31:0] value;
	logic [7:0]         position;

	modport source (output valid, cmd, value, position, input ready);
	modport sink (input valid, cmd, value, position, output ready);
endinterface

interface ate_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               found;
	logic signed [31:0] read_value;
	logic [7:0]         count;

	modport source (output valid, status, found, read_value, count, input ready);
	modport sink (input valid, status, found, read_value, count, output ready);
endinterface

[src/array_table_engine_core.sv]
// ----------------------------------------------------------------------------
// array_table_engine_core
// Ordered word store with append, insert, delete, sort, search, read, clear.
//
//  channel  | direction | handshake         | contents
//  ---------+-----------+-------------------+--------------------------------
//  in_ch    | in        | valid / ready     | cmd, value, position
//  out_ch   | out       | valid / ready     | status, found, read_value, count
//  apb      | in        | psel/penable      | capacity at byte address 0
//
// Insert and delete move or scan the entries one at a time, set by the single
// read and write port of the entry memory. Sort runs an insertion sort; search
// sorts first and then halves the range. Reset clears the count and sets
// capacity to 128; entry contents are kept undefined. A finished result waits
// in the output register while the next command is accepted.
// ----------------------------------------------------------------------------
module array_table_engine_core #(
	parameter int DEPTH = ate_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ate_in_if.sink      in_ch,
	ate_out_if.source   out_ch
);

	logic [7:0] capacity_q;
	ate_pkg::dp_ctl_t   ctl;
	ate_pkg::dp_flags_t flags;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= ate_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			capacity_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == 1'b0) ? {24'd0, capacity_q} : 32'd0;

	ate_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.flags     (flags),
		.ctl       (ctl)
	);

	ate_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.flags          (flags),
		.capacity       (capacity_q),
		.in_cmd         (in_ch.cmd),
		.in_value       (in_ch.value),
		.in_position    (in_ch.position),
		.out_status     (out_ch.status),
		.out_found      (out_ch.found),
		.out_read_value (out_ch.read_value),
		.out_count      (out_ch.count)
	);

endmodule

[src/ate_ctrl.sv]
// ----------------------------------------------------------------------------
// ate_ctrl
// Command sequencer: steps the datapath through each command.
// ----------------------------------------------------------------------------
module ate_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ate_pkg::dp_flags_t flags,
	output ate_pkg::dp_ctl_t   ctl
);

	ate_pkg::state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ate_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ate_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ate_pkg::S_IDLE: begin
				if (in_valid) state_d = ate_pkg::S_DECODE;
			end
			ate_pkg::S_DECODE: begin
				unique case (flags.cmd)
					ate_pkg::CMD_INSERT: begin
						state_d = (flags.full || flags.ins_bad) ? ate_pkg::S_FIN
							: ate_pkg::S_INS_CHK;
					end
					ate_pkg::CMD_DELETE: state_d = ate_pkg::S_DEL_CHK;
					ate_pkg::CMD_SORT, ate_pkg::CMD_SEARCH: state_d = ate_pkg::S_SRT_OUT;
					ate_pkg::CMD_READ: begin
						state_d = flags.rd_bad ? ate_pkg::S_FIN : ate_pkg::S_RD_DATA;
					end
					default: state_d = ate_pkg::S_FIN;
				endcase
			end
			ate_pkg::S_INS_CHK: begin
				state_d = flags.j_at_ins ? ate_pkg::S_FIN : ate_pkg::S_INS_WR;
			end
			ate_pkg::S_INS_WR: state_d = ate_pkg::S_INS_CHK;
			ate_pkg::S_DEL_CHK: begin
				state_d = flags.j_at_count ? ate_pkg::S_FIN : ate_pkg::S_DEL_CMP;
			end
			ate_pkg::S_DEL_CMP: begin
				state_d = flags.eq_value ? ate_pkg::S_DEL_SH : ate_pkg::S_DEL_CHK;
			end
			ate_pkg::S_DEL_SH: begin
				state_d = flags.j_last ? ate_pkg::S_FIN : ate_pkg::S_DEL_WR;
			end
			ate_pkg::S_DEL_WR: state_d = ate_pkg::S_DEL_SH;
			ate_pkg::S_SRT_OUT: begin
				if (!flags.i_done) begin
					state_d = ate_pkg::S_SRT_KEY;
				end else if (flags.cmd == ate_pkg::CMD_SEARCH) begin
					state_d = ate_pkg::S_BS_CHK;
				end else begin
					state_d = ate_pkg::S_FIN;
				end
			end
			ate_pkg::S_SRT_KEY: state_d = ate_pkg::S_SRT_CHK;
			ate_pkg::S_SRT_CHK: begin
				state_d = flags.j_zero ? ate_pkg::S_SRT_OUT : ate_pkg::S_SRT_CMP;
			end
			ate_pkg::S_SRT_CMP: begin
				state_d = flags.gt_key ? ate_pkg::S_SRT_CHK : ate_pkg::S_SRT_OUT;
			end
			ate_pkg::S_BS_CHK: begin
				state_d = flags.lo_ge_hi ? ate_pkg::S_FIN : ate_pkg::S_BS_CMP;
			end
			ate_pkg::S_BS_CMP: begin
				state_d = flags.eq_value ? ate_pkg::S_FIN : ate_pkg::S_BS_CHK;
			end
			ate_pkg::S_RD_DATA: state_d = ate_pkg::S_FIN;
			ate_pkg::S_FIN: begin
				if (!out_valid_q || out_ready) state_d = ate_pkg::S_IDLE;
			end
			default: state_d = ate_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ate_pkg::S_IDLE: ctl.latch = in_valid;
			ate_pkg::S_DECODE: begin
				unique case (flags.cmd)
					ate_pkg::CMD_APPEND: begin
						if (flags.full) begin
							ctl.st_ld  = 1'b1;
							ctl.st_val = ate_pkg::ST_FULL;
						end else begin
							ctl.mem_wr    = 1'b1;
							ctl.waddr_sel = ate_pkg::WA_COUNT;
							ctl.wdata_sel = ate_pkg::WD_VALUE;
							ctl.cnt_op    = ate_pkg::C_INC;
						end
					end
					ate_pkg::CMD_INSERT: begin
						if (flags.full) begin
							ctl.st_ld  = 1'b1;
							ctl.st_val = ate_pkg::ST_FULL;
						end else if (flags.ins_bad) begin
							ctl.st_ld  = 1'b1;
							ctl.st_val = ate_pkg::ST_RANGE;
						end else begin
							ctl.j_op = ate_pkg::J_COUNT;
						end
					end
					ate_pkg::CMD_DELETE: ctl.j_op = ate_pkg::J_ZERO;
					ate_pkg::CMD_SORT, ate_pkg::CMD_SEARCH: ctl.i_op = ate_pkg::I_ONE;
					ate_pkg::CMD_READ: begin
						if (flags.rd_bad) begin
							ctl.st_ld  = 1'b1;
							ctl.st_val = ate_pkg::ST_RANGE;
						end else begin
							ctl.mem_rd    = 1'b1;
							ctl.raddr_sel = ate_pkg::RA_POS;
						end
					end
					ate_pkg::CMD_CLEAR: ctl.cnt_op = ate_pkg::C_CLR;
					default: ;
				endcase
			end
			ate_pkg::S_INS_CHK: begin
				if (flags.j_at_ins) begin
					ctl.mem_wr    = 1'b1;
					ctl.waddr_sel = ate_pkg::WA_J;
					ctl.wdata_sel = ate_pkg::WD_VALUE;
					ctl.cnt_op    = ate_pkg::C_INC;
				end else begin
					ctl.mem_rd    = 1'b1;
					ctl.raddr_sel = ate_pkg::RA_JM1;
				end
			end
			ate_pkg::S_INS_WR: begin
				ctl.mem_wr    = 1'b1;
				ctl.waddr_sel = ate_pkg::WA_J;
				ctl.wdata_sel = ate_pkg::WD_RDATA;
				ctl.j_op      = ate_pkg::J_DEC;
			end
			ate_pkg::S_DEL_CHK: begin
				if (flags.j_at_count) begin
					ctl.st_ld  = 1'b1;
					ctl.st_val = ate_pkg::ST_NOTFOUND;
				end else begin
					ctl.mem_rd    = 1'b1;
					ctl.raddr_sel = ate_pkg::RA_J;
				end
			end
			ate_pkg::S_DEL_CMP: begin
				if (!flags.eq_value) ctl.j_op = ate_pkg::J_INC;
			end
			ate_pkg::S_DEL_SH: begin
				if (flags.j_last) begin
					ctl.cnt_op = ate_pkg::C_DEC;
				end else begin
					ctl.mem_rd    = 1'b1;
					ctl.raddr_sel = ate_pkg::RA_JP1;
				end
			end
			ate_pkg::S_DEL_WR: begin
				ctl.mem_wr    = 1'b1;
				ctl.waddr_sel = ate_pkg::WA_J;
				ctl.wdata_sel = ate_pkg::WD_RDATA;
				ctl.j_op      = ate_pkg::J_INC;
			end
			ate_pkg::S_SRT_OUT: begin
				if (!flags.i_done) begin
					ctl.mem_rd    = 1'b1;
					ctl.raddr_sel = ate_pkg::RA_I;
				end else if (flags.cmd == ate_pkg::CMD_SEARCH) begin
					ctl.bs_op = ate_pkg::BS_INIT;
				end
			end
			ate_pkg::S_SRT_KEY: begin
				ctl.key_ld = 1'b1;
				ctl.j_op   = ate_pkg::J_I;
			end
			ate_pkg::S_SRT_CHK: begin
				if (flags.j_zero) begin
					ctl.mem_wr    = 1'b1;
					ctl.waddr_sel = ate_pkg::WA_J;
					ctl.wdata_sel = ate_pkg::WD_KEY;
					ctl.i_op      = ate_pkg::I_INC;
				end else begin
					ctl.mem_rd    = 1'b1;
					ctl.raddr_sel = ate_pkg::RA_JM1;
				end
			end
			ate_pkg::S_SRT_CMP: begin
				ctl.mem_wr    = 1'b1;
				ctl.waddr_sel = ate_pkg::WA_J;
				if (flags.gt_key) begin
					ctl.wdata_sel = ate_pkg::WD_RDATA;
					ctl.j_op      = ate_pkg::J_DEC;
				end else begin
					ctl.wdata_sel = ate_pkg::WD_KEY;
					ctl.i_op      = ate_pkg::I_INC;
				end
			end
			ate_pkg::S_BS_CHK: begin
				if (flags.lo_ge_hi) begin
					ctl.st_ld  = 1'b1;
					ctl.st_val = ate_pkg::ST_NOTFOUND;
				end else begin
					ctl.mem_rd    = 1'b1;
					ctl.raddr_sel = ate_pkg::RA_MID;
					ctl.j_op      = ate_pkg::J_MID;
				end
			end
			ate_pkg::S_BS_CMP: begin
				if (flags.eq_value) begin
					ctl.found_set = 1'b1;
				end else if (flags.lt_value) begin
					ctl.bs_op = ate_pkg::BS_HI;
				end else begin
					ctl.bs_op = ate_pkg::BS_LO;
				end
			end
			ate_pkg::S_RD_DATA: ctl.rd_ld = 1'b1;
			ate_pkg::S_FIN: ctl.out_ld = !out_valid_q || out_ready;
			default: ;
		endcase
	end

endmodule

[src/ate_datapath.sv]
// ----------------------------------------------------------------------------
// ate_datapath
// Entry memory, index registers, comparators and the result register.
// ----------------------------------------------------------------------------
module ate_datapath #(
	parameter int DEPTH = ate_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ate_pkg::dp_ctl_t    ctl,
	output ate_pkg::dp_flags_t  flags,
	input  logic [7:0]          capacity,
	input  logic [2:0]          in_cmd,
	input  logic signed [31:0]  in_value,
	input  logic [7:0]          in_position,
	output logic [1:0]          out_status,
	output logic                out_found,
	output logic signed [31:0]  out_read_value,
	output logic [7:0]          out_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	ate_pkg::cmd_t      cmd_q;
	logic signed [31:0] value_q;
	logic [7:0]         pos_q;
	logic [7:0]         count_q;
	logic [7:0]         j_q;
	logic [7:0]         i_q;
	logic [7:0]         lo_q;
	logic [7:0]         hi_q;
	logic [31:0]        key_q;
	ate_pkg::status_t   status_q;
	logic               found_q;
	logic [31:0]        rd_q;

	logic [7:0]    j_m1;
	logic [8:0]    j_p1;
	logic [7:0]    mid;
	logic [8:0]    mid_p1;
	logic [7:0]    raddr8;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	assign j_m1   = j_q - 8'd1;
	assign j_p1   = {1'b0, j_q} + 9'd1;
	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign mid_p1 = {1'b0, j_q} + 9'd1;

	always_comb begin
		unique case (ctl.raddr_sel)
			ate_pkg::RA_J:   raddr8 = j_q;
			ate_pkg::RA_JM1: raddr8 = j_m1;
			ate_pkg::RA_JP1: raddr8 = j_p1[7:0];
			ate_pkg::RA_MID: raddr8 = mid;
			ate_pkg::RA_POS: raddr8 = pos_q;
			ate_pkg::RA_I:   raddr8 = i_q;
			default:         raddr8 = j_q;
		endcase
	end

	assign raddr = AW'(raddr8);
	assign waddr = (ctl.waddr_sel == ate_pkg::WA_COUNT) ? AW'(count_q) : AW'(j_q);

	always_comb begin
		unique case (ctl.wdata_sel)
			ate_pkg::WD_VALUE: wdata = value_q;
			ate_pkg::WD_RDATA: wdata = rdata_q;
			ate_pkg::WD_KEY:   wdata = key_q;
			default:           wdata = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem[waddr] <= wdata;
		end
		if (ctl.mem_rd) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
		end else begin
			unique case (ctl.cnt_op)
				ate_pkg::C_INC:  count_q <= count_q + 8'd1;
				ate_pkg::C_DEC:  count_q <= count_q - 8'd1;
				ate_pkg::C_CLR:  count_q <= 8'd0;
				default:         count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q    <= ate_pkg::cmd_t'(in_cmd);
			value_q  <= in_value;
			pos_q    <= in_position;
			status_q <= ate_pkg::ST_OK;
			found_q  <= 1'b0;
			rd_q     <= 32'd0;
		end
		if (ctl.st_ld) status_q <= ctl.st_val;
		if (ctl.found_set) found_q <= 1'b1;
		if (ctl.rd_ld) rd_q <= rdata_q;
		if (ctl.key_ld) key_q <= rdata_q;

		unique case (ctl.j_op)
			ate_pkg::J_COUNT: j_q <= count_q;
			ate_pkg::J_ZERO:  j_q <= 8'd0;
			ate_pkg::J_I:     j_q <= i_q;
			ate_pkg::J_DEC:   j_q <= j_m1;
			ate_pkg::J_INC:   j_q <= j_p1[7:0];
			ate_pkg::J_MID:   j_q <= mid;
			default:          j_q <= j_q;
		endcase

		unique case (ctl.i_op)
			ate_pkg::I_ONE: i_q <= 8'd1;
			ate_pkg::I_INC: i_q <= i_q + 8'd1;
			default:        i_q <= i_q;
		endcase

		unique case (ctl.bs_op)
			ate_pkg::BS_INIT: begin
				lo_q <= 8'd0;
				hi_q <= count_q;
			end
			ate_pkg::BS_LO: lo_q <= mid_p1[7:0];
			ate_pkg::BS_HI: hi_q <= j_q;
			default: ;
		endcase

		if (ctl.out_ld) begin
			out_status     <= status_q;
			out_found      <= found_q;
			out_read_value <= rd_q;
			out_count      <= count_q;
		end
	end

	always_comb begin
		flags.cmd        = cmd_q;
		flags.full       = (count_q >= capacity) || (int'(count_q) >= DEPTH);
		flags.ins_bad    = (pos_q == 8'd0) || ({1'b0, pos_q} > ({1'b0, count_q} + 9'd1));
		flags.rd_bad     = (pos_q >= count_q);
		flags.j_at_ins   = (j_p1 == {1'b0, pos_q});
		flags.j_zero     = (j_q == 8'd0);
		flags.j_at_count = (j_q == count_q);
		flags.j_last     = (j_p1 == {1'b0, count_q});
		flags.i_done     = (i_q >= count_q);
		flags.eq_value   = (rdata_q == value_q);
		flags.gt_key     = ($signed(rdata_q) > $signed(key_q));
		flags.lt_value   = (value_q < $signed(rdata_q));
		flags.lo_ge_hi   = (lo_q >= hi_q);
	end

endmodule

[test/array_table_engine_core_chk.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_table_engine_core_chk
// Watches the command and result channels, keeps its own copy of the word
// store and count, works out the result of each accepted command and compares
// it field by field with the result that the block returns.
// ----------------------------------------------------------------------------
module array_table_engine_core_chk
	import ate_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  capacity,
	ate_in_if           in_ch,
	ate_out_if          out_ch,
	output int          errors,
	output int          pending
);

	typedef struct {
		status_t            status;
		logic               found;
		logic signed [31:0] read_value;
		logic [7:0]         count;
	} table_result_t;

	logic signed [31:0] words [DEPTH];
	int unsigned        used;
	table_result_t      expected_q [$];

	function automatic void sort_words();
		int unsigned n;
		int j;
		logic signed [31:0] key;
		n = (used < DEPTH) ? used : DEPTH;
		for (int unsigned i = 1; i < n; i++) begin
			key = words[i];
			j = i;
			while (j > 0 && words[j-1] > key) begin
				words[j] = words[j-1];
				j--;
			end
			words[j] = key;
		end
	endfunction

	function automatic logic search_words(logic signed [31:0] v);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = used;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (words[mid] == v) return 1'b1;
			if (v < words[mid]) hi = mid;
			else lo = mid + 1;
		end
		return 1'b0;
	endfunction

	function automatic table_result_t apply_command(cmd_t cmd, logic signed [31:0] v,
			logic [7:0] pos);
		table_result_t r;
		int unsigned lim, hit;
		r.status = ST_OK;
		r.found = 1'b0;
		r.read_value = '0;
		lim = (capacity < DEPTH) ? capacity : DEPTH;
		case (cmd)
			CMD_APPEND: begin
				if (used >= lim) r.status = ST_FULL;
				else begin
					words[used] = v;
					used++;
				end
			end
			CMD_INSERT: begin
				if (used >= lim) r.status = ST_FULL;
				else if (pos == 0 || pos > used + 1) r.status = ST_RANGE;
				else begin
					for (int unsigned i = used; i > pos - 1; i--) words[i] = words[i-1];
					words[pos-1] = v;
					used++;
				end
			end
			CMD_DELETE: begin
				hit = used;
				for (int unsigned i = 0; i < used; i++)
					if (words[i] == v) begin
						hit = i;
						break;
					end
				if (hit == used) r.status = ST_NOTFOUND;
				else begin
					for (int unsigned i = hit; i + 1 < used; i++) words[i] = words[i+1];
					used--;
				end
			end
			CMD_SORT: sort_words();
			CMD_SEARCH: begin
				sort_words();
				r.found = search_words(v);
				if (!r.found) r.status = ST_NOTFOUND;
			end
			CMD_READ: begin
				if (pos < used) r.read_value = words[pos];
				else r.status = ST_RANGE;
			end
			CMD_CLEAR: used = 0;
			default: ;
		endcase
		r.count = used[7:0];
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		table_result_t e;
		if (!arst_n) begin
			used = 0;
			errors = 0;
			expected_q.delete();
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_q.push_back(apply_command(cmd_t'(in_ch.cmd), in_ch.value,
					in_ch.position));
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with no command outstanding");
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (out_ch.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, out_ch.status);
						errors++;
					end
					if (out_ch.found !== e.found) begin
						$error("found: expected %0d, got %0d", e.found, out_ch.found);
						errors++;
					end
					if (out_ch.read_value !== e.read_value) begin
						$error("read_value: expected %0d, got %0d", e.read_value,
							out_ch.read_value);
						errors++;
					end
					if (out_ch.count !== e.count) begin
						$error("count: expected %0d, got %0d", e.count, out_ch.count);
						errors++;
					end
				end
			end
		end
	end

endmodule

[test/array_table_engine_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_table_engine_core_tb
// Drives directed and random command sequences into the array table engine
// under several capacity settings and flow-control patterns, and reports the
// verdict from the checker beside it.
// ----------------------------------------------------------------------------
module array_table_engine_core_tb;
	import ate_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic [7:0]  capacity = CAPACITY_RESET;
	int          errors;
	int          pending;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;
	logic signed [31:0] pool [8];

	ate_in_if  in_ch ();
	ate_out_if out_ch ();

	array_table_engine_core dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	array_table_engine_core_chk chk (
		.clk(clk), .arst_n(arst_n), .capacity(capacity), .in_ch(in_ch),
		.out_ch(out_ch), .errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.value = '0;
		in_ch.position = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_command(cmd_t cmd, logic signed [31:0] v, logic [7:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.value <= v;
		in_ch.position <= pos;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_capacity(logic [7:0] c);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= {24'h0, c};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		capacity = c;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(20)) - 10;
			default: return pool[$urandom_range(7)];
		endcase
	endfunction

	task automatic random_commands(int n);
		int c, fill;
		cmd_t cmd;
		fill = 0;
		for (int k = 0; k < n; k++) begin
			c = $urandom_range(99);
			if (c < 30) cmd = CMD_APPEND;
			else if (c < 50) cmd = CMD_INSERT;
			else if (c < 63) cmd = CMD_DELETE;
			else if (c < 68) cmd = CMD_SORT;
			else if (c < 78) cmd = CMD_SEARCH;
			else if (c < 94) cmd = CMD_READ;
			else if (c < 96) cmd = CMD_CLEAR;
			else cmd = CMD_NOP;
			fill = chk.used + 2;
			send_command(cmd, pick_value(),
				($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(fill)));
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) pool[i] = $urandom;
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7fff_ffff;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(CMD_READ, 0, 0);
		send_command(CMD_DELETE, 5, 0);
		send_command(CMD_SEARCH, 5, 0);
		send_command(CMD_APPEND, 32'h7fff_ffff, 0);
		send_command(CMD_APPEND, 32'h8000_0000, 0);
		send_command(CMD_INSERT, -1, 1);
		send_command(CMD_INSERT, 0, 4);
		send_command(CMD_INSERT, 3, 6);
		send_command(CMD_INSERT, 3, 0);
		send_command(CMD_INSERT, 3, 8'hff);
		send_command(CMD_READ, 0, 3);
		send_command(CMD_READ, 0, 4);
		send_command(CMD_READ, 0, 8'hff);
		send_command(CMD_SORT, 0, 0);
		send_command(CMD_SEARCH, 32'h8000_0000, 0);
		send_command(CMD_SEARCH, 32'h7fff_ffff, 0);
		send_command(CMD_SEARCH, 12345, 0);
		send_command(CMD_DELETE, -1, 0);
		send_command(CMD_DELETE, -1, 0);
		send_command(CMD_NOP, 32'hffff_ffff, 8'hff);
		send_command(CMD_CLEAR, 0, 0);

		write_capacity(8'd1);
		send_command(CMD_APPEND, 1, 0);
		send_command(CMD_APPEND, 2, 0);
		send_command(CMD_INSERT, 2, 1);
		write_capacity(8'd0);
		send_command(CMD_APPEND, 3, 0);
		write_capacity(8'd255);
		send_command(CMD_CLEAR, 0, 0);

		write_capacity(8'd128);
		for (int k = 0; k < 130; k++) send_command(CMD_APPEND, $urandom, 0);
		send_command(CMD_INSERT, 0, 1);
		send_command(CMD_READ, 0, 127);
		send_command(CMD_INSERT, 0, 8'd129);
		send_command(CMD_SEARCH, pool[0], 0);
		send_command(CMD_DELETE, pool[0], 0);
		send_command(CMD_INSERT, 7, 8'd128);
		send_command(CMD_CLEAR, 0, 0);

		random_commands(150);
		write_capacity(8'd6);
		send_idle_pct = 48;
		random_commands(120);
		drain();
		write_capacity(8'd20);
		send_idle_pct = 0;
		stall_pct = 48;
		random_commands(120);
		write_capacity(8'd3);
		send_idle_pct = 7;
		stall_pct = 7;
		random_commands(100);
		write_capacity(8'd64);
		send_idle_pct = 0;
		stall_pct = 0;
		random_commands(100);

		drain();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
